@@ src/three_voice_sine_synth_with_lfo_top_macros.svh @@
// assertion macros used by tvss_back
`ifndef THREE_VOICE_SINE_SYNTH_WITH_LFO_TOP_MACROS_SVH
`define THREE_VOICE_SINE_SYNTH_WITH_LFO_TOP_MACROS_SVH

// same-cycle implication
`define TVSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tvss_pkg.sv @@
`default_nettype none

package tvss_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int STEP_BITS       = 32;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int NUM_VOICES      = 3;

  localparam int QTR_LEN = 1 << TABLE_ADDR_BITS;
  localparam int ROM_W   = SAMPLE_BITS - 1;
  localparam int ROM_AW  = TABLE_ADDR_BITS + 1;

  localparam longint AMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // 0.3 in q0.16
  localparam int MIX_GAIN  = 19661;
  localparam int GAIN_BITS = 16;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TONE_LOW   = 0,
    REG_TONE_MID   = 1,
    REG_TONE_HIGH  = 2,
    REG_PULSE_LOW  = 3,
    REG_PULSE_MID  = 4,
    REG_PULSE_HIGH = 5
  } cfg_reg_t;

  // head of the request queue
  typedef struct packed {
    logic valid;
    logic advance;
  } q_status_t;

  typedef longint unsigned u64_t;

  typedef logic [ROM_W-1:0] sine_rom_t [0:QTR_LEN];

  // shift and subtract quotient, used only while building the table
  function automatic u64_t div_u64(input u64_t num, input u64_t den);
    u64_t q;
    u64_t r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & u64_t'(1));
      if (r >= den) begin
        r = r - den;
        q = q | (u64_t'(1) << b);
      end
    end
    return q;
  endfunction

  // quarter-wave sine, taylor series in q30, evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    u64_t x;
    u64_t term;
    longint acc;
    longint v;
    for (int i = 0; i <= QTR_LEN; i++) begin
      x    = (u64_t'(i) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 9; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = div_u64(term, u64_t'((2 * k) * (2 * k + 1)));
        if ((k & 1) == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = (acc * AMP_MAX + (longint'(1) << 29)) >>> 30;
      if (v > AMP_MAX) v = AMP_MAX;
      t[i] = ROM_W'(v);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

@@ src/tvss_in_if.sv @@
`default_nettype none

interface tvss_in_if ();
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

`default_nettype wire

@@ src/tvss_out_if.sv @@
`default_nettype none

interface tvss_out_if import tvss_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ src/tvss_cfg_if.sv @@
`default_nettype none

interface tvss_cfg_if import tvss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [STEP_BITS-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/tvss_front.sv @@
`default_nettype none

// two-entry request queue
module tvss_front import tvss_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  tvss_in_if.sink     din,
  input  wire logic   pop,
  output q_status_t   head
);

  logic [1:0] entry;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign din.ready = (count != 2'd2);
  assign push      = din.valid && din.ready;

  assign head.valid   = (count != 2'd0);
  assign head.advance = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/tvss_back.sv @@
`default_nettype none

`include "three_voice_sine_synth_with_lfo_top_macros.svh"

// phase accumulators, shared sine table and multiplier, mix and output register
module tvss_back import tvss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_status_t head,
  output logic           pop,
  tvss_cfg_if.sink       cfg,
  tvss_out_if.source     dout
);

  localparam int ADD_W   = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W   = PROD_W + 2;
  localparam int MAG_W   = PROD_W + 1;
  localparam int SC_W    = MAG_W + GAIN_BITS;
  localparam int SHIFT   = SAMPLE_BITS - 1 + GAIN_BITS;
  localparam int RND_W   = SC_W - SHIFT;
  localparam int ISSUES  = 2 * NUM_VOICES;
  localparam int LOOK_LAST = ISSUES + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_MAG  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [STEP_BITS-1:0]  tone_step  [0:NUM_VOICES-1];
  logic [STEP_BITS-1:0]  pulse_step [0:NUM_VOICES-1];
  logic [PHASE_BITS-1:0] tone_phase  [0:NUM_VOICES-1];
  logic [PHASE_BITS-1:0] pulse_phase [0:NUM_VOICES-1];

  logic [2:0]                    cnt;
  logic                          issue;
  logic [1:0]                    voice;
  logic [PHASE_BITS-1:0]         sel_phase;
  logic [1:0]                    quad;
  logic [TABLE_ADDR_BITS-1:0]    taddr;
  logic [ROM_AW-1:0]             idx;

  logic                          rom_vld;
  logic [ROM_W-1:0]              rom_q;
  logic                          rom_neg;
  logic                          rom_pulse;
  logic signed [SAMPLE_BITS-1:0] sval;
  logic signed [SAMPLE_BITS-1:0] tone_val;
  logic                          prod_vld;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SUM_W-1:0]       sum;
  logic                          neg_res;
  logic [MAG_W-1:0]              mag;
  logic [SC_W-1:0]               scaled;
  logic [RND_W-1:0]              rnd;
  logic signed [SAMPLE_BITS-1:0] res;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_free;
  logic                          load;

  function automatic logic [PHASE_BITS-1:0] phase_add(
    input logic [PHASE_BITS-1:0] p,
    input logic [STEP_BITS-1:0]  s
  );
    return PHASE_BITS'(ADD_W'(p) + ADD_W'(s));
  endfunction

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_step[0]  <= STEP_BITS'(16800042);
      tone_step[1]  <= STEP_BITS'(25200063);
      tone_step[2]  <= STEP_BITS'(33600084);
      pulse_step[0] <= STEP_BITS'(48696);
      pulse_step[1] <= STEP_BITS'(50644);
      pulse_step[2] <= STEP_BITS'(53078);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TONE_LOW:   tone_step[0]  <= cfg.data;
        REG_TONE_MID:   tone_step[1]  <= cfg.data;
        REG_TONE_HIGH:  tone_step[2]  <= cfg.data;
        REG_PULSE_LOW:  pulse_step[0] <= cfg.data;
        REG_PULSE_MID:  pulse_step[1] <= cfg.data;
        REG_PULSE_HIGH: pulse_step[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (head.valid) state_next = S_LOOK;
      S_LOOK: if (cnt == 3'(LOOK_LAST)) state_next = S_MAG;
      S_MAG:  state_next = S_MUL;
      S_MUL:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      if (state == S_LOOK) cnt <= cnt + 3'd1;
      else cnt <= 3'd0;
    end
  end

  // lookup order: tone, pulse of voice 0, then voice 1, then voice 2
  assign issue = (state == S_LOOK) && (cnt < 3'(ISSUES));
  assign voice = cnt[2:1];

  always_comb begin
    case (voice)
      2'd0:    sel_phase = cnt[0] ? pulse_phase[0] : tone_phase[0];
      2'd1:    sel_phase = cnt[0] ? pulse_phase[1] : tone_phase[1];
      2'd2:    sel_phase = cnt[0] ? pulse_phase[2] : tone_phase[2];
      default: sel_phase = '0;
    endcase
  end

  assign quad  = sel_phase[PHASE_BITS-1 -: 2];
  assign taddr = sel_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign idx   = quad[0] ? (ROM_AW'(QTR_LEN) - ROM_AW'(taddr)) : ROM_AW'(taddr);

  assign sval = rom_neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_vld  <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rom_vld  <= issue;
      prod_vld <= rom_vld && rom_pulse;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rom_q     <= SINE_ROM[idx];
      rom_neg   <= quad[1];
      rom_pulse <= cnt[0];
    end
    if (rom_vld) begin
      if (rom_pulse) prod <= tone_val * sval;
      else tone_val <= sval;
    end
    if (state == S_IDLE) sum <= '0;
    else if (prod_vld) sum <= sum + SUM_W'(prod);
    if (state == S_MAG) begin
      neg_res <= sum[SUM_W-1];
      mag     <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    end
    if (state == S_MUL) begin
      scaled <= mag * SC_W'(MIX_GAIN);
    end
  end

  // round half away from zero on the magnitude, then saturate
  assign rnd = RND_W'((scaled + (SC_W'(1) << (SHIFT - 1))) >> SHIFT);

  always_comb begin
    if (!neg_res) begin
      res = (rnd > RND_W'(AMP_MAX)) ? SAMPLE_BITS'(AMP_MAX) : SAMPLE_BITS'(rnd);
    end else begin
      res = (rnd > RND_W'(AMP_MAX + 1)) ? SAMPLE_BITS'(-AMP_MAX - 1)
                                        : -$signed(SAMPLE_BITS'(rnd));
    end
  end

  // output register
  assign out_free = !out_valid || dout.ready;
  assign load     = (state == S_DONE) && out_free;
  assign pop      = load;

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_sample <= res;
  end

  // phases move only when the sample of the current phases is loaded, and only on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        tone_phase[v]  <= '0;
        pulse_phase[v] <= '0;
      end
    end else if (load && head.advance) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        tone_phase[v]  <= phase_add(tone_phase[v], tone_step[v]);
        pulse_phase[v] <= phase_add(pulse_phase[v], pulse_step[v]);
      end
    end
  end

  `TVSS_ASSERT_NOW(a_pop_needs_request, pop, head.valid, "pop with empty queue")
  `TVSS_ASSERT_NOW(a_prod_in_look, prod_vld || rom_vld, state == S_LOOK, "pipeline outside lookup")
  `TVSS_ASSERT_NEXT(a_phase_hold, !load, $stable(tone_phase[0]) && $stable(pulse_phase[0]), "phase moved outside done")

endmodule

`default_nettype wire

@@ src/three_voice_sine_synth_with_lfo_top.sv @@
// channel  dir  payload                          role
// din      in   advance (1)                      sample request, 1 = step phases after
// dout     out  sample_out (SAMPLE_BITS, signed) mixed q1.15 sample of all three voices
// cfg      in   index (3), data (32)             phase step registers 0..5
//
// one request runs from queue head to output register through the six sine lookups in
// the single table and multiplier pipeline, then magnitude, gain multiply, round/load,
// and a return to idle before the next request at the queue head
// rst is synchronous, clears phases, queue and output valid, and loads the default steps
// a two-entry queue lets din take one more request while the sequencer is busy
// a stalled dout holds the sequencer in its last step; phases advance only on load
`default_nettype none

module three_voice_sine_synth_with_lfo_top import tvss_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  tvss_in_if.sink     din,
  tvss_out_if.source  dout,
  tvss_cfg_if.sink    cfg
);

  // queue head from front to back
  q_status_t head;
  // request done, sample loaded into output register
  logic      pop;

  // front: takes requests and queues them
  tvss_front u_front (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .pop  (pop),
    .head (head)
  );

  // back: lookups, products, mix, rounding, phase update
  tvss_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .cfg  (cfg),
    .dout (dout)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import tvss_pkg::*; ();

  // generous bound on cycles without any handshake
  localparam int WATCHDOG_LIMIT = 4000;
  // cycles to let the pipeline settle before touching the step registers
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_ITEMS   = 900;
  localparam int MIX_SHIFT      = SAMPLE_BITS - 1 + GAIN_BITS;

  // indexes outside the register map, writes must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_B = 3'd7;

  logic clk;
  logic rst;

  tvss_in_if  din ();
  tvss_out_if dout ();
  tvss_cfg_if cfg ();

  three_voice_sine_synth_with_lfo_top DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cfg  (cfg)
  );

  // ---------------------------------------------------------------------------
  // shadow of the synth: sine table, phase steps and phase accumulators
  // ---------------------------------------------------------------------------
  longint                sine_lut [0:QTR_LEN];
  logic [STEP_BITS-1:0]  tone_step  [NUM_VOICES];
  logic [STEP_BITS-1:0]  pulse_step [NUM_VOICES];
  logic [PHASE_BITS-1:0] tone_ph    [NUM_VOICES];
  logic [PHASE_BITS-1:0] pulse_ph   [NUM_VOICES];

  // requests waiting to be driven, samples waiting to come out
  logic                          pending_advance  [$];
  logic signed [SAMPLE_BITS-1:0] expected_samples [$];

  int mismatch_count;
  int quiet_cycles;
  bit calm_phase;

  // quarter-wave table, taylor series in q30, rounded half up
  function automatic void fill_sine_lut();
    longint unsigned x;
    longint unsigned term;
    longint acc;
    longint v;
    for (int i = 0; i <= QTR_LEN; i++) begin
      x    = i;
      x    = (x * HALF_PI_Q30) / QTR_LEN;
      term = x;
      acc  = x;
      for (int k = 1; k <= 9; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) acc = 0;
      v = (acc * AMP_MAX + (longint'(1) << 29)) >>> 30;
      if (v > AMP_MAX) v = AMP_MAX;
      sine_lut[i] = v;
    end
  endfunction

  // top two bits pick the quadrant, the next bits address the table
  function automatic longint sine_at(input logic [PHASE_BITS-1:0] ph);
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] addr;
    int                         idx;
    longint                     v;
    quad = ph[PHASE_BITS-1 -: 2];
    addr = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    idx  = quad[0] ? (QTR_LEN - int'(addr)) : int'(addr);
    v    = sine_lut[idx];
    return quad[1] ? -v : v;
  endfunction

  // sum of tone times lfo, scaled by 0.3, rounded half away from zero
  function automatic logic signed [SAMPLE_BITS-1:0] mix_now();
    longint          acc;
    longint unsigned mag;
    longint          r;
    acc = 0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      acc += sine_at(tone_ph[v]) * sine_at(pulse_ph[v]);
    end
    acc = acc * MIX_GAIN;
    mag = (acc < 0) ? longint'(-acc) : acc;
    mag = (mag + (64'd1 << (MIX_SHIFT - 1))) >> MIX_SHIFT;
    r   = mag;
    if (acc < 0) r = -r;
    if (r > AMP_MAX) r = AMP_MAX;
    if (r < -AMP_MAX - 1) r = -AMP_MAX - 1;
    return r[SAMPLE_BITS-1:0];
  endfunction

  // sample comes from the current phases, then all phases step if advance is set
  function automatic void forecast_sample(input logic adv);
    expected_samples.push_back(mix_now());
    if (adv) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        tone_ph[v]  = tone_ph[v] + tone_step[v];
        pulse_ph[v] = pulse_ph[v] + pulse_step[v];
      end
    end
  endfunction

  function automatic void apply_step_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input logic [STEP_BITS-1:0] val);
    case (idx)
      REG_TONE_LOW:   tone_step[0]  = val;
      REG_TONE_MID:   tone_step[1]  = val;
      REG_TONE_HIGH:  tone_step[2]  = val;
      REG_PULSE_LOW:  pulse_step[0] = val;
      REG_PULSE_MID:  pulse_step[1] = val;
      REG_PULSE_HIGH: pulse_step[2] = val;
      default: ;
    endcase
  endfunction

  // step values biased toward the edges of the register range
  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 32'h0001_0000);
      4:       return $urandom_range(0, 32'h0400_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic int draw_wait();
    return calm_phase ? 0 : $urandom_range(0, 17);
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // request driver: pops pending items, random gap after each
  // ---------------------------------------------------------------------------
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      din.valid   <= 1'b0;
      din.advance <= 1'b0;
      gap_left    <= 0;
    end else if (!din.valid || din.ready) begin
      // a request taken at this edge feeds the shadow model
      if (din.valid) forecast_sample(din.advance);
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        din.valid <= 1'b0;
      end else if (pending_advance.size() > 0) begin
        din.valid   <= 1'b1;
        din.advance <= pending_advance.pop_front();
        gap_left    <= draw_wait();
      end else begin
        din.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample monitor: random back-pressure, compares against the oldest forecast
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin : sample_mon
    int s;
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst) begin
      dout.ready <= 1'b0;
      stall_left <= 0;
    end else if (dout.valid && dout.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: no sample expected, got %0d", dout.sample_out);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        if (dout.sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, dout.sample_out);
          mismatch_count++;
        end
      end
      s = draw_wait();
      stall_left <= s;
      dout.ready <= (s == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      dout.ready <= (stall_left == 1);
    end else begin
      dout.ready <= 1'b1;
    end
  end

  // step register writes land in the shadow copy
  always @(posedge clk) begin
    if (!rst && cfg.valid && cfg.ready) apply_step_write(cfg.index, cfg.data);
  end

  // ---------------------------------------------------------------------------
  // watchdog: any handshake clears it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[three_voice_sine_synth_with_lfo_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequencing
  // ---------------------------------------------------------------------------

  // one register write, held until the port takes it
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [STEP_BITS-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic write_all_steps(input logic [STEP_BITS-1:0] val);
    for (int r = REG_TONE_LOW; r <= REG_PULSE_HIGH; r++) write_reg(r[CFG_INDEX_BITS-1:0], val);
  endtask

  // sender holds off until every forecast sample has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_advance.size() != 0 || din.valid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_requests(input logic [31:0] pattern, input int n);
    @(negedge clk);
    for (int i = 0; i < n; i++) pending_advance.push_back(pattern[i]);
  endtask

  initial begin : stimulus
    int queued;
    int n;

    fill_sine_lut();
    // reset state of the shadow model
    tone_step[0]  = 32'd16800042;
    tone_step[1]  = 32'd25200063;
    tone_step[2]  = 32'd33600084;
    pulse_step[0] = 32'd48696;
    pulse_step[1] = 32'd50644;
    pulse_step[2] = 32'd53078;
    for (int v = 0; v < NUM_VOICES; v++) begin
      tone_ph[v]  = '0;
      pulse_ph[v] = '0;
    end
    mismatch_count = 0;
    quiet_cycles   = 0;
    calm_phase     = 1'b0;

    // every block input known from time zero
    rst         = 1'b1;
    din.valid   = 1'b0;
    din.advance = 1'b0;
    dout.ready  = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset steps: silence at zero phase, holds with advance low, then steps
    queue_requests(32'b1011_1100, 8);
    wait_idle();

    // half-turn steps flip the quadrant on every advancing sample
    write_all_steps(32'h8000_0000);
    queue_requests(32'b11011, 5);
    wait_idle();

    // largest steps, phases wrap on every advancing sample
    write_all_steps(32'hFFFF_FFFF);
    queue_requests(32'b0111, 4);
    wait_idle();

    // zero steps freeze the phases; unmapped indexes change nothing
    write_all_steps('0);
    write_reg(REG_UNUSED_A, $urandom());
    write_reg(REG_UNUSED_B, $urandom());
    queue_requests(32'b1101, 4);
    wait_idle();

    // quarter-turn, three-quarter-turn and tiny tone steps against slow, zero and near half-turn lfo steps
    write_reg(REG_TONE_LOW,   32'h4000_0000);
    write_reg(REG_TONE_MID,   32'hC000_0000);
    write_reg(REG_TONE_HIGH,  32'h0000_0001);
    write_reg(REG_PULSE_LOW,  32'h0010_0000);
    write_reg(REG_PULSE_MID,  32'h0000_0000);
    write_reg(REG_PULSE_HIGH, 32'h7FFF_FFFF);
    queue_requests(32'b1111, 4);
    wait_idle();

    // random phases of random length, new steps in between
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      for (int r = REG_TONE_LOW; r <= REG_PULSE_HIGH; r++) begin
        if ($urandom_range(0, 3) != 0) write_reg(r[CFG_INDEX_BITS-1:0], pick_step());
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom());
      end
      n = $urandom_range(20, 80);
      @(negedge clk);
      // about one phase in four runs with no idling on either side
      calm_phase = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) pending_advance.push_back($urandom_range(0, 9) != 0);
      queued += n;
      wait_idle();
    end

    if (expected_samples.size() != 0) begin
      $error("sample_out: %0d expected samples never arrived", expected_samples.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[three_voice_sine_synth_with_lfo_top] OK");
    end else begin
      $display("[three_voice_sine_synth_with_lfo_top] ERROR");
    end
    $finish;
  end

endmodule
